// File: rtl/dse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dse_pkg;

    localparam int unsigned  DATA_W    = 32;
    localparam int unsigned  ACC_W     = 50;
    localparam int unsigned  CNT_W     = $clog2(DATA_W + 1);
    localparam logic [31:0]  POS_ONE   = 32'd16777216;
    localparam logic [31:0]  S32_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0]  S32_MIN   = 32'h8000_0000;
    localparam logic [31:0]  MASS_RST  = 32'd327680;
    localparam logic [31:0]  STIFF_RST = 32'd655360;
    localparam logic [31:0]  DAMP_RST  = 32'd327680;
    localparam logic [31:0]  DT_RST    = 32'd7158279;

    localparam logic [1:0] CFG_MASS  = 2'd0;
    localparam logic [1:0] CFG_STIFF = 2'd1;
    localparam logic [1:0] CFG_DAMP  = 2'd2;
    localparam logic [1:0] CFG_DT    = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_A1, S_B1, S_D1, S_W1,
        S_A2, S_B2, S_D2, S_W2,
        S_M5, S_U5, S_U6,
        S_M7, S_A7, S_B7, S_D7, S_W7,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        MS_NONE, MS_YK, MS_VB, MS_AM, MS_WDT, MS_A1DT
    } t_mul_sel;

    typedef enum logic [2:0] {
        AO_NONE, AO_LOAD_NEG, AO_SUB, AO_Y_ADD, AO_V_ADD
    } t_acc_op;

    typedef enum logic [1:0] {
        DD_A1, DD_W, DD_ACC
    } t_div_dst;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     div_start;
        t_div_dst div_dst;
        logic     restart;
        logic     step;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// File: rtl/dse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dse_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_restart,
    output logic                   o_in_stall,
    input  wire dse_pkg::t_status  i_status,
    output dse_pkg::t_cmd          o_cmd
);
    import dse_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = i_in_restart ? S_FIN : S_M1;
            S_M1:   n_state = S_A1;
            S_A1:   n_state = S_B1;
            S_B1:   n_state = S_D1;
            S_D1:   n_state = S_W1;
            S_W1:   if (i_status.div_done) n_state = S_A2;
            S_A2:   n_state = S_B2;
            S_B2:   n_state = S_D2;
            S_D2:   n_state = S_W2;
            S_W2:   if (i_status.div_done) n_state = S_M5;
            S_M5:   n_state = S_U5;
            S_U5:   n_state = S_U6;
            S_U6:   n_state = S_M7;
            S_M7:   n_state = S_A7;
            S_A7:   n_state = S_B7;
            S_B7:   n_state = S_D7;
            S_D7:   n_state = S_W7;
            S_W7:   if (i_status.div_done) n_state = S_FIN;
            S_FIN:  if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.mul_sel   = MS_NONE;
        o_cmd.acc_op    = AO_NONE;
        o_cmd.div_dst   = DD_A1;
        o_cmd.restart   = accept && i_in_restart;
        o_cmd.step      = accept && !i_in_restart;
        case (r_state)
            S_M1:  o_cmd.mul_sel = MS_YK;
            S_A1:  begin o_cmd.acc_op = AO_LOAD_NEG; o_cmd.mul_sel = MS_VB; end
            S_B1:  o_cmd.acc_op = AO_SUB;
            S_D1:  begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_dst   = DD_A1;
                o_cmd.mul_sel   = MS_YK;
            end
            S_A2:  begin o_cmd.acc_op = AO_LOAD_NEG; o_cmd.mul_sel = MS_AM; end
            S_B2:  o_cmd.acc_op = AO_SUB;
            S_D2:  begin o_cmd.div_start = 1'b1; o_cmd.div_dst = DD_W; end
            S_M5:  o_cmd.mul_sel = MS_WDT;
            S_U5:  begin o_cmd.acc_op = AO_Y_ADD; o_cmd.mul_sel = MS_A1DT; end
            S_U6:  o_cmd.acc_op = AO_V_ADD;
            S_M7:  o_cmd.mul_sel = MS_YK;
            S_A7:  begin o_cmd.acc_op = AO_LOAD_NEG; o_cmd.mul_sel = MS_VB; end
            S_B7:  o_cmd.acc_op = AO_SUB;
            S_D7:  begin o_cmd.div_start = 1'b1; o_cmd.div_dst = DD_ACC; end
            S_FIN: o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// File: rtl/dse_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module dse_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data,
    input  wire dse_pkg::t_cmd     i_cmd,
    output dse_pkg::t_status       o_status,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic signed [31:0]     o_out_position,
    output logic signed [31:0]     o_out_velocity,
    output logic signed [31:0]     o_out_acceleration,
    output logic                   o_out_saturated
);
    import dse_pkg::*;

    // configuration
    logic [31:0] r_mass, r_stiff, r_damp, r_dt;
    // motion state and intermediates
    logic [31:0] r_y, r_v, r_a, r_a1, r_w;
    logic        r_flag;
    // shared multiplier and accumulator
    logic [63:0]       r_prod;
    logic              r_pneg;
    logic [ACC_W-1:0]  r_acc;
    // divider
    logic              r_div_busy, r_div_done, r_div_neg;
    logic [CNT_W-1:0]  r_div_cnt;
    logic [31:0]       r_rem, r_dq, r_dd;
    t_div_dst          r_div_dst;
    // output register
    logic              r_out_valid;
    logic [31:0]       r_out_y, r_out_v, r_out_a;
    logic              r_out_flag;

    function automatic logic [32:0] sat_add(input logic [33:0] x);
        logic [32:0] res;
        if (!x[33] && (x[32:31] != 2'b00))      res = {1'b1, S32_MAX};
        else if (x[33] && (x[32:31] != 2'b11))  res = {1'b1, S32_MIN};
        else                                     res = {1'b0, x[31:0]};
        return res;
    endfunction

    // apply sign and clip an unsigned quotient
    function automatic logic [32:0] quo_fix(input logic [31:0] q, input logic neg);
        logic [32:0] res;
        if (neg) begin
            if (q > S32_MIN) res = {1'b1, S32_MIN};
            else             res = {1'b0, 32'(-q)};
        end else begin
            if (q > S32_MAX) res = {1'b1, S32_MAX};
            else             res = {1'b0, q};
        end
        return res;
    endfunction

    // multiplier operands
    logic [31:0] mul_s, mul_u, s_mag;
    always_comb begin
        mul_s = r_y;
        mul_u = r_stiff;
        case (i_cmd.mul_sel)
            MS_YK:   begin mul_s = r_y;  mul_u = r_stiff; end
            MS_VB:   begin mul_s = r_v;  mul_u = r_damp;  end
            MS_AM:   begin mul_s = r_a;  mul_u = r_mass;  end
            MS_WDT:  begin mul_s = r_w;  mul_u = r_dt;    end
            MS_A1DT: begin mul_s = r_a1; mul_u = r_dt;    end
            default: ;
        endcase
        s_mag = mul_s[31] ? 32'(-mul_s) : mul_s;
    end

    // product terms, truncated toward zero
    logic [ACC_W-1:0] term16;
    logic [33:0]      term32, y_sum, v_sum;
    logic [32:0]      y_sat, v_sat;
    always_comb begin
        term16 = {2'b00, r_prod[63:16]};
        if (r_pneg) term16 = -term16;
        term32 = {2'b00, r_prod[63:32]};
        if (r_pneg) term32 = -term32;
        y_sum = {{2{r_y[31]}}, r_y} + term32;
        v_sum = {{2{r_v[31]}}, r_v} + term32;
        y_sat = sat_add(y_sum);
        v_sat = sat_add(v_sum);
    end

    // divider start checks and one restoring step
    logic              st_neg, st_zero, st_sat;
    logic [ACC_W-1:0]  st_mag;
    logic [31:0]       st_hi, st_div;
    logic [32:0]       rem2, st_res, fin_res;
    logic              ge;
    always_comb begin
        st_neg  = r_acc[ACC_W-1];
        st_mag  = st_neg ? -r_acc : r_acc;
        st_hi   = st_mag[47:16];
        st_div  = (i_cmd.div_dst == DD_W) ? r_damp : r_mass;
        st_zero = (st_mag == '0);
        st_sat  = (st_div == '0) || (st_hi >= st_div);
        st_res  = st_zero ? 33'd0 : {1'b1, (st_neg ? S32_MIN : S32_MAX)};
        rem2    = {r_rem, r_dq[31]};
        ge      = (rem2 >= {1'b0, r_dd});
        fin_res = quo_fix({r_dq[30:0], ge}, r_div_neg);
    end

    logic        div_wr;
    logic [32:0] div_res;
    t_div_dst    div_wdst;
    always_comb begin
        div_wr   = 1'b0;
        div_res  = st_res;
        div_wdst = i_cmd.div_dst;
        if (i_cmd.div_start && (st_zero || st_sat)) begin
            div_wr = 1'b1;
        end else if (r_div_busy && (r_div_cnt == CNT_W'(1))) begin
            div_wr   = 1'b1;
            div_res  = fin_res;
            div_wdst = r_div_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass      <= MASS_RST;
            r_stiff     <= STIFF_RST;
            r_damp      <= DAMP_RST;
            r_dt        <= DT_RST;
            r_y         <= POS_ONE;
            r_v         <= '0;
            r_a         <= '0;
            r_flag      <= 1'b0;
            r_div_busy  <= 1'b0;
            r_div_done  <= 1'b0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MASS:  r_mass  <= i_cfg_data;
                    CFG_STIFF: r_stiff <= i_cfg_data;
                    CFG_DAMP:  r_damp  <= i_cfg_data;
                    CFG_DT:    r_dt    <= i_cfg_data;
                    default: ;
                endcase
            end

            r_div_done <= div_wr;
            if (i_cmd.div_start && !(st_zero || st_sat)) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= CNT_W'(DATA_W);
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt - CNT_W'(1);
                if (r_div_cnt == CNT_W'(1)) r_div_busy <= 1'b0;
            end

            if (i_cmd.restart) begin
                r_y    <= POS_ONE;
                r_v    <= '0;
                r_a    <= '0;
                r_flag <= 1'b0;
            end else begin
                if (i_cmd.step) r_flag <= 1'b0;
                if (i_cmd.acc_op == AO_Y_ADD) begin
                    r_y <= y_sat[31:0];
                    if (y_sat[32]) r_flag <= 1'b1;
                end
                if (i_cmd.acc_op == AO_V_ADD) begin
                    r_v <= v_sat[31:0];
                    if (v_sat[32]) r_flag <= 1'b1;
                end
                if (div_wr) begin
                    case (div_wdst)
                        DD_A1:   r_a1 <= div_res[31:0];
                        DD_W:    r_w  <= div_res[31:0];
                        DD_ACC:  r_a  <= div_res[31:0];
                        default: ;
                    endcase
                    if (div_res[32]) r_flag <= 1'b1;
                end
            end

            if (i_cmd.out_load)    r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sel != MS_NONE) begin
            r_prod <= 64'(s_mag) * 64'(mul_u);
            r_pneg <= mul_s[31];
        end
        case (i_cmd.acc_op)
            AO_LOAD_NEG: r_acc <= -term16;
            AO_SUB:      r_acc <= r_acc - term16;
            default: ;
        endcase
        if (i_cmd.div_start) begin
            r_rem     <= st_hi;
            r_dq      <= {st_mag[15:0], 16'h0000};
            r_dd      <= st_div;
            r_div_neg <= st_neg;
            r_div_dst <= i_cmd.div_dst;
        end else if (r_div_busy) begin
            r_rem <= ge ? 32'(rem2 - {1'b0, r_dd}) : rem2[31:0];
            r_dq  <= {r_dq[30:0], ge};
        end
        if (i_cmd.out_load) begin
            r_out_y    <= r_y;
            r_out_v    <= r_v;
            r_out_a    <= r_a;
            r_out_flag <= r_flag;
        end
    end

    assign o_status.div_done  = r_div_done;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_position     = r_out_y;
    assign o_out_velocity     = r_out_v;
    assign o_out_acceleration = r_out_a;
    assign o_out_saturated    = r_out_flag;

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> (r_div_cnt != '0))
        else $error("divider busy with zero step count");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_div_busy)
        else $error("division started while divider busy");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a pending word");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_done |-> !r_div_busy)
        else $error("divider done while still busy");

endmodule
`default_nettype wire

// File: rtl/damped_spring_euler_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Damped mass-spring integrator: one explicit Euler step per input word.
// Input channel: i_in_valid / o_in_stall with i_in_restart. A word with
// restart set restores y = 1.0, v = 0, a = 0; otherwise the block advances
// the motion by one step of length time_step.
// Output channel: o_out_valid / i_out_stall with position, velocity and
// acceleration (signed Q8.24) and a saturated flag for clipping in the step.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), index 0 mass,
// 1 spring_stiffness, 2 damping, 3 time_step. Write only while idle.
// Sequence: a step word's result passes through three division waits on one
// shared restoring divider (cut short when the quotient saturates or the
// numerator is zero) and 15 multiply, accumulate, divider-start, update
// and load states on one shared 32x32 multiplier. A restart word goes
// straight to the load state.
// One word is worked on at a time; the input stall drops as the result is
// loaded into the output register, and only then is a new word taken.
// Reset: synchronous, active low; configuration takes its default values,
// the output valid clears and the motion returns to y = 1.0, v = 0, a = 0.
// Stall: a pending result holds in the output register; a finished step
// waits for it to be taken before it is loaded.
module damped_spring_euler_step (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_restart,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_out_position,
    output logic signed [31:0]      o_out_velocity,
    output logic signed [31:0]      o_out_acceleration,
    output logic                    o_out_saturated,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import dse_pkg::*;

    t_cmd    cmd;
    t_status status;

    // configuration writes go straight into registers, so always accept
    assign o_cfg_ready = 1'b1;

    // sequence the step: multiply, accumulate, divide, update
    dse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_restart (i_in_restart),
        .o_in_stall   (o_in_stall),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // hold the state, configuration, arithmetic units and output register
    dse_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_out_position     (o_out_position),
        .o_out_velocity     (o_out_velocity),
        .o_out_acceleration (o_out_acceleration),
        .o_out_saturated    (o_out_saturated)
    );

endmodule
`default_nettype wire
